[hdl/dam_pkg.sv]
// Shared types, constants and bit-manipulation helpers for the DRAM address mapper.
package dam_pkg;

    localparam int unsigned ADDR_W    = 36;
    localparam int unsigned BANK_W    = 3;
    localparam int unsigned ROW_W     = 16;
    localparam int unsigned COL_W     = 10;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMM_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ENABLE = 2'd3;

    // Count value that enables the two-way split
    localparam logic [1:0] COUNT_TWO = 2'd2;

    localparam logic [ROW_W-1:0] ROW_KEEP_MASK  = 16'hfe07;
    localparam logic [BANK_W-1:0] BANK_KEEP_MASK = 3'b100;
    localparam logic [ROW_W-1:0] ROW_FLIP_MASK  = 16'h0006;

    typedef struct packed {
        logic [1:0] channel_count;
        logic [1:0] dimm_count;
        logic [1:0] rank_count;
        logic       mirror_enable;
    } cfg_t;

    typedef struct packed {
        logic              channel;
        logic              dimm;
        logic              rank;
        logic [BANK_W-1:0] bank;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
    } result_t;

    // Swap bit pairs 3/4, 5/6 and 7/8 (DDR3 address mirroring)
    function automatic logic [ROW_W-1:0] swap_pairs(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] r;
        r    = v & ROW_KEEP_MASK;
        r[8] = v[7];
        r[7] = v[8];
        r[6] = v[5];
        r[5] = v[6];
        r[4] = v[3];
        r[3] = v[4];
        return r;
    endfunction

endpackage

[hdl/dam_if.sv]
// Valid/ready channel interfaces for addresses in and DRAM coordinates out.
interface dam_req_if;
    logic                         valid;
    logic                         ready;
    logic [dam_pkg::ADDR_W-1:0]   phys_addr;

    modport source (output valid, output phys_addr, input ready);
    modport sink   (input valid, input phys_addr, output ready);
endinterface

interface dam_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         channel;
    logic                         dimm;
    logic                         rank;
    logic [dam_pkg::BANK_W-1:0]   bank;
    logic [dam_pkg::ROW_W-1:0]    row;
    logic [dam_pkg::COL_W-1:0]    column;

    modport source (output valid, output channel, output dimm, output rank,
                    output bank, output row, output column, input ready);
    modport sink   (input valid, input channel, input dimm, input rank,
                    input bank, input row, input column, output ready);
endinterface

[hdl/dram_address_mapper.sv]
// Top level of the DRAM address mapper: config registers, input and result stages.
//
// Usage:
//   req  : sink channel carrying a 36-bit physical byte address per transaction.
//   rsp  : source channel carrying channel, DIMM, rank, bank, row and column.
//   cfg_we/cfg_index/cfg_data : write-only register port (channel_count,
//          dimm_count, rank_count, mirror_enable); write only while idle.
// Timing:
//   An address is captured in the input stage, decoded by one pass of
//   select/XOR logic and lands in the result register, which drives
//   rsp.valid. One transaction per cycle sustained while rsp.ready is high;
//   the decode path between the two stages sets the clock limit.
// Reset:
//   Both stages empty, registers at one channel, one DIMM, two ranks,
//   mirroring off.
// Backpressure:
//   While rsp.ready is low the result holds; the input stage still takes
//   one more transaction, after which req.ready drops until rsp drains.
module dram_address_mapper (
    input  logic                              clk,
    input  logic                              rst_n,
    dam_req_if.sink                           req,
    dam_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [dam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dam_pkg::CFG_DATA_W-1:0]    cfg_data
);

    dam_pkg::cfg_t              cfg_reg;
    dam_pkg::cfg_t              cfg_next;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [dam_pkg::ADDR_W-1:0] s1_addr_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    dam_pkg::result_t           out_data_reg;

    dam_pkg::result_t           map_result;
    logic                       s1_ready;
    logic                       s2_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dam_pkg::CFG_CHANNEL_COUNT: cfg_next.channel_count = cfg_data;
                dam_pkg::CFG_DIMM_COUNT:    cfg_next.dimm_count    = cfg_data;
                dam_pkg::CFG_RANK_COUNT:    cfg_next.rank_count    = cfg_data;
                dam_pkg::CFG_MIRROR_ENABLE: cfg_next.mirror_enable = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count <= 2'd1;
            cfg_reg.dimm_count    <= 2'd1;
            cfg_reg.rank_count    <= 2'd2;
            cfg_reg.mirror_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s2_ready  = !out_valid_reg || rsp.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    always_comb
    begin
        s1_valid_next  = s1_ready ? req.valid : s1_valid_reg;
        out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_addr_reg <= req.phys_addr;
        end
        if (s2_ready && s1_valid_reg)
        begin
            out_data_reg <= map_result;
        end
    end

    dam_map_core u_core (
        .addr   (s1_addr_reg),
        .cfg    (cfg_reg),
        .result (map_result)
    );

    assign rsp.valid   = out_valid_reg;
    assign rsp.channel = out_data_reg.channel;
    assign rsp.dimm    = out_data_reg.dimm;
    assign rsp.rank    = out_data_reg.rank;
    assign rsp.bank    = out_data_reg.bank;
    assign rsp.row     = out_data_reg.row;
    assign rsp.column  = out_data_reg.column;

endmodule

[hdl/dam_map_core.sv]
// Combinational address decode: channel/DIMM/rank extraction, bank hash, mirroring.
module dam_map_core (
    input  logic [dam_pkg::ADDR_W-1:0] addr,
    input  dam_pkg::cfg_t              cfg,
    output dam_pkg::result_t           result
);

    logic [dam_pkg::ADDR_W-1:0] a_chan;
    logic [dam_pkg::ADDR_W-1:0] a_dimm;
    logic [dam_pkg::ADDR_W-1:0] a_rank;
    logic                       chan_bit;
    logic                       dimm_bit;
    logic                       rank_bit;
    logic [dam_pkg::COL_W-1:0]  col_raw;
    logic [dam_pkg::BANK_W-1:0] bank_raw;
    logic [dam_pkg::ROW_W-1:0]  row_raw;
    logic [dam_pkg::ROW_W-1:0]  row_mir;
    logic [dam_pkg::ROW_W-1:0]  col_wide;
    logic [dam_pkg::ROW_W-1:0]  col_mir;
    logic [dam_pkg::BANK_W-1:0] bank_mir;
    logic                       mirror;

    always_comb
    begin
        // Channel bit 6 is squeezed out in two-channel mode
        if (cfg.channel_count == dam_pkg::COUNT_TWO)
        begin
            chan_bit = addr[6];
            a_chan   = {1'b0, addr[35:7], addr[5:0]};
        end
        else
        begin
            chan_bit = 1'b0;
            a_chan   = addr;
        end

        col_raw = a_chan[12:3];

        if (cfg.dimm_count == dam_pkg::COUNT_TWO)
        begin
            dimm_bit = a_chan[16];
            a_dimm   = {1'b0, a_chan[35:17], a_chan[15:0]};
        end
        else
        begin
            dimm_bit = 1'b0;
            a_dimm   = a_chan;
        end

        if (cfg.rank_count == dam_pkg::COUNT_TWO)
        begin
            rank_bit = a_dimm[16] ^ a_dimm[20];
            a_rank   = {1'b0, a_dimm[35:17], a_dimm[15:0]};
        end
        else
        begin
            rank_bit = 1'b0;
            a_rank   = a_dimm;
        end

        bank_raw = a_rank[15:13] ^ a_rank[18:16];
        row_raw  = a_rank[31:16];

        mirror   = cfg.mirror_enable & rank_bit;
        col_wide = {{(dam_pkg::ROW_W-dam_pkg::COL_W){1'b0}}, col_raw};
        row_mir  = dam_pkg::swap_pairs(row_raw);
        col_mir  = dam_pkg::swap_pairs(col_wide);
        bank_mir = (bank_raw & dam_pkg::BANK_KEEP_MASK) | {1'b0, bank_raw[0], bank_raw[1]};

        result.channel = chan_bit;
        result.dimm    = dimm_bit;
        result.rank    = rank_bit;
        result.bank    = mirror ? bank_mir : bank_raw;
        result.column  = mirror ? col_mir[dam_pkg::COL_W-1:0] : col_raw;
        result.row     = (mirror ? row_mir : row_raw)
                         ^ (a_rank[19] ? dam_pkg::ROW_FLIP_MASK : '0);
    end

endmodule

[hdl/dam_checker.sv]
// Port-level checker for the DRAM address mapper, bound to the top level.
module dam_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic                              rsp_channel,
    input logic                              rsp_dimm,
    input logic                              rsp_rank,
    input logic [dam_pkg::BANK_W-1:0]        rsp_bank,
    input logic [dam_pkg::ROW_W-1:0]         rsp_row,
    input logic [dam_pkg::COL_W-1:0]         rsp_column,
    input logic                              cfg_we,
    input logic [dam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [dam_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic two_chan_reg;
    logic two_dimm_reg;
    logic two_rank_reg;

    // Shadow of the count registers as seen on the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_chan_reg <= 1'b0;
            two_dimm_reg <= 1'b0;
            two_rank_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == dam_pkg::CFG_CHANNEL_COUNT)
                two_chan_reg <= (cfg_data == dam_pkg::COUNT_TWO);
            if (cfg_index == dam_pkg::CFG_DIMM_COUNT)
                two_dimm_reg <= (cfg_data == dam_pkg::COUNT_TWO);
            if (cfg_index == dam_pkg::CFG_RANK_COUNT)
                two_rank_reg <= (cfg_data == dam_pkg::COUNT_TWO);
        end
    end

    a_rsp_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp.valid dropped before the transaction completed");

    a_rsp_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable({rsp_channel, rsp_dimm, rsp_rank, rsp_bank, rsp_row, rsp_column}))
        else $error("rsp payload changed while stalled");

    a_single_channel: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_channel |-> two_chan_reg)
        else $error("nonzero channel in single-channel mode");

    a_single_dimm: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_dimm |-> two_dimm_reg)
        else $error("nonzero DIMM in single-DIMM mode");

    a_single_rank: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_rank |-> two_rank_reg)
        else $error("nonzero rank in single-rank mode");

endmodule

bind dram_address_mapper dam_checker u_dam_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_channel (rsp.channel),
    .rsp_dimm    (rsp.dimm),
    .rsp_rank    (rsp.rank),
    .rsp_bank    (rsp.bank),
    .rsp_row     (rsp.row),
    .rsp_column  (rsp.column),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
);

[bench/tb_dram_address_mapper.sv]
`timescale 1ns / 100ps
// Self-checking testbench for dram_address_mapper: random and directed address decodes.
module tb_dram_address_mapper;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned RAND_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS  = 230;

    localparam logic [dam_pkg::ROW_W-1:0] ROW_BIT_FLIP = 16'h0006;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [dam_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dam_pkg::CFG_DATA_W-1:0] cfg_data;

    dam_req_if req_ch ();
    dam_rsp_if rsp_ch ();

    dram_address_mapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dam_pkg::cfg_t    cur_cfg;
    dam_pkg::result_t expected_coords[$];
    int unsigned      mismatch_count;
    int unsigned      cycle_count;
    int unsigned      gap_pct;
    int unsigned      stall_pct;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("dram_address_mapper: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // remove bit pos, shifting the upper bits down
    function automatic logic [dam_pkg::ADDR_W-1:0] drop_bit(
        input logic [dam_pkg::ADDR_W-1:0] v, input int unsigned pos);
        logic [dam_pkg::ADDR_W-1:0] low;
        low = ({{(dam_pkg::ADDR_W-1){1'b0}}, 1'b1} << pos) - 1'b1;
        return ((v >> 1) & ~low) | (v & low);
    endfunction

    function automatic logic [dam_pkg::ROW_W-1:0] mirror_bits(
        input logic [dam_pkg::ROW_W-1:0] v);
        logic [dam_pkg::ROW_W-1:0] r;
        r = v & dam_pkg::ROW_KEEP_MASK;
        r = r | ({15'd0, v[7]} << 8) | ({15'd0, v[8]} << 7)
              | ({15'd0, v[5]} << 6) | ({15'd0, v[6]} << 5)
              | ({15'd0, v[3]} << 4) | ({15'd0, v[4]} << 3);
        return r;
    endfunction

    function automatic dam_pkg::result_t map_address(input dam_pkg::cfg_t c,
                                                     input logic [dam_pkg::ADDR_W-1:0] pa);
        logic [dam_pkg::ADDR_W-1:0] a;
        logic [dam_pkg::ROW_W-1:0]  col16;
        logic [dam_pkg::ROW_W-1:0]  row16;
        logic [dam_pkg::BANK_W-1:0] bk;
        dam_pkg::result_t           r;
        r = '0;
        a = pa;
        if (c.channel_count == dam_pkg::COUNT_TWO)
        begin
            r.channel = a[6];
            a = drop_bit(a, 6);
        end
        col16 = {6'd0, a[12:3]};
        if (c.dimm_count == dam_pkg::COUNT_TWO)
        begin
            r.dimm = a[16];
            a = drop_bit(a, 16);
        end
        if (c.rank_count == dam_pkg::COUNT_TWO)
        begin
            r.rank = a[16] ^ a[20];
            a = drop_bit(a, 16);
        end
        bk    = a[15:13] ^ a[18:16];
        row16 = a[31:16];
        if (c.mirror_enable && r.rank)
        begin
            row16 = mirror_bits(row16);
            col16 = mirror_bits(col16);
            bk    = {bk[2], bk[0], bk[1]};
        end
        if (a[19])
            row16 = row16 ^ ROW_BIT_FLIP;
        r.bank   = bk;
        r.row    = row16;
        r.column = col16[dam_pkg::COL_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        dam_pkg::result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_coords.size() == 0)
            begin
                $display("%0t: unexpected transaction expected none actual row %0h col %0h",
                         $time, rsp_ch.row, rsp_ch.column);
                mismatch_count++;
            end
            else
            begin
                want = expected_coords.pop_front();
                check_field("channel", 32'(want.channel), 32'(rsp_ch.channel));
                check_field("dimm",    32'(want.dimm),    32'(rsp_ch.dimm));
                check_field("rank",    32'(want.rank),    32'(rsp_ch.rank));
                check_field("bank",    32'(want.bank),    32'(rsp_ch.bank));
                check_field("row",     32'(want.row),     32'(rsp_ch.row));
                check_field("column",  32'(want.column),  32'(rsp_ch.column));
            end
        end
    end

    task automatic put_reg(input logic [dam_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dam_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // raw values so that out-of-range counts and the unused mirror bit get exercised
    task automatic write_config(input logic [1:0] ch, input logic [1:0] dm,
                                input logic [1:0] rk, input logic [1:0] mr);
        put_reg(dam_pkg::CFG_CHANNEL_COUNT, ch);
        put_reg(dam_pkg::CFG_DIMM_COUNT, dm);
        put_reg(dam_pkg::CFG_RANK_COUNT, rk);
        put_reg(dam_pkg::CFG_MIRROR_ENABLE, mr);
        cfg_we <= 1'b0;
        cur_cfg.channel_count = ch;
        cur_cfg.dimm_count    = dm;
        cur_cfg.rank_count    = rk;
        cur_cfg.mirror_enable = mr[0];
    endtask

    task automatic send_address(input logic [dam_pkg::ADDR_W-1:0] addr);
        while ($urandom_range(99, 0) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.phys_addr <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_coords.push_back(map_address(cur_cfg, addr));
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_coords.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_edge_addresses();
        send_address(36'h0_0000_0000);
        send_address(36'hF_FFFF_FFFF);
        send_address(36'h0_0000_0040);
        send_address(36'h0_0001_0000);
        send_address(36'h0_0010_0000);
        send_address(36'h0_0008_0000);
        send_address(36'hA_AAAA_AAAA);
        send_address(36'h5_5555_5555);
    endtask

    function automatic logic [dam_pkg::ADDR_W-1:0] random_address();
        logic [dam_pkg::ADDR_W-1:0] a;
        a = {4'($urandom_range(15, 0)), $urandom()};
        case ($urandom_range(7, 0))
            0: a = {{(dam_pkg::ADDR_W-1){1'b0}}, 1'b1} << $urandom_range(dam_pkg::ADDR_W-1, 0);
            1: a = ~({{(dam_pkg::ADDR_W-1){1'b0}}, 1'b1}
                     << $urandom_range(dam_pkg::ADDR_W-1, 0));
            2: a = a & 36'h0_FFFF_FFFF;
            default: ;
        endcase
        return a;
    endfunction

    task automatic test_reset_defaults();
        gap_pct   = 0;
        stall_pct = 0;
        send_edge_addresses();
        wait_for_results();
    endtask

    task automatic test_full_split_mirrored();
        write_config(2'd2, 2'd2, 2'd2, 2'd1);
        send_edge_addresses();
        wait_for_results();
    endtask

    task automatic test_odd_register_values();
        write_config(2'd0, 2'd3, 2'd0, 2'd3);
        send_address(36'hF_FFFF_FFFF);
        send_address(36'h0_0011_0040);
        wait_for_results();
        write_config(2'd3, 2'd0, 2'd3, 2'd2);
        send_address(36'hF_FFFF_FFFF);
        send_address(36'h0_0019_1F78);
        wait_for_results();
        write_config(2'd1, 2'd1, 2'd1, 2'd1);
        send_address(36'hF_FFFF_FFFF);
        send_address(36'h0_0019_1F78);
        wait_for_results();
    endtask

    task automatic test_random_mappings();
        for (int unsigned ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: write_config(2'd1, 2'd1, 2'd1, 2'd0);
                1: write_config(2'd2, 2'd2, 2'd2, 2'd1);
                2: write_config(2'd2, 2'd1, 2'd2, 2'd1);
                default: write_config(2'($urandom_range(3, 0)), 2'($urandom_range(3, 0)),
                                      2'($urandom_range(3, 0)), 2'($urandom_range(3, 0)));
            endcase
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 79; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 79; end
                default: begin gap_pct = 16; stall_pct = 16; end
            endcase
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off mid-phase until the pipeline is empty
                if (n == PHASE_ITEMS / 2)
                    wait_for_results();
                send_address(random_address());
            end
            wait_for_results();
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.phys_addr = '0;
        mismatch_count   = 0;
        cycle_count      = 0;
        gap_pct          = 0;
        stall_pct        = 0;
        cur_cfg.channel_count = 2'd1;
        cur_cfg.dimm_count    = 2'd1;
        cur_cfg.rank_count    = 2'd2;
        cur_cfg.mirror_enable = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_full_split_mirrored();
        test_odd_register_values();
        test_random_mappings();

        wait_for_results();
        if (mismatch_count == 0)
            $display("dram_address_mapper: match");
        else
            $display("dram_address_mapper: mismatch");
        $finish;
    end

endmodule

[files.f]
hdl/dam_pkg.sv
hdl/dam_if.sv
hdl/dam_map_core.sv
hdl/dram_address_mapper.sv
hdl/dam_checker.sv
bench/tb_dram_address_mapper.sv
